FILE: hdl/efv_pkg.sv
// Shared types and constants for the event frame validator.
// No dependencies; every other file refers to this package by scoped name.
`default_nettype none

package efv_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 7;
  localparam int unsigned OutTdataW  = 16;
  localparam int unsigned SeenW      = 3;
  localparam int unsigned PhaseW     = 2;

  localparam logic [ByteW-1:0]  HeaderByte       = 8'd172;
  localparam int unsigned       FlagBitIdx       = 7;
  localparam logic [SeenW-1:0]  MinLength        = 3'd5;
  localparam logic [SeenW-1:0]  FirstByteSeen    = 3'd1;
  localparam logic [PhaseW-1:0] PhaseAfterHeader = 2'd2;
  localparam logic [PhaseW-1:0] PhaseRecordEnd   = 2'd0;

  typedef enum logic [1:0] {
    VERDICT_INCOMPLETE = 2'd0,
    VERDICT_VALID      = 2'd1,
    VERDICT_INVALID    = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    logic             frame_start;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] record_count;
    verdict_e          verdict;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/efv_in_stage.sv
// Input register of the event frame validator: holds one received byte request.
// Depends on efv_pkg for the item type.
`default_nettype none

module efv_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  efv_pkg::item_t     item_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output efv_pkg::item_t     item_o
);

  logic           valid_q;
  logic           valid_d;
  efv_pkg::item_t item_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: hdl/efv_frame_check.sv
// Frame state and verdict logic: updates counters, phase and checksum per byte.
// Depends on efv_pkg for constants, the item type and the result type.
`default_nettype none

module efv_frame_check #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          advance_i,
  input  efv_pkg::item_t     item_i,
  output efv_pkg::result_t   result_o
);

  localparam int unsigned RecW = $clog2(MAX_RECORDS + 1);

  logic                          header_good_q, header_good_d;
  logic [efv_pkg::SeenW-1:0]     bytes_seen_q, bytes_seen_d;
  logic [efv_pkg::PhaseW-1:0]    length_phase_q, length_phase_d;
  logic [efv_pkg::ByteW-1:0]     previous_byte_q, previous_byte_d;
  logic [efv_pkg::ByteW-1:0]     running_sum_q, running_sum_d;
  logic [RecW-1:0]               records_seen_q, records_seen_d;
  logic [RecW+efv_pkg::CountW-1:0] records_ext;
  logic                          new_frame;
  logic                          closes_frame;

  always_comb begin
    new_frame       = item_i.frame_start || (bytes_seen_q == '0);
    header_good_d   = header_good_q;
    bytes_seen_d    = bytes_seen_q;
    length_phase_d  = length_phase_q;
    records_seen_d  = records_seen_q;
    if (new_frame) begin
      header_good_d  = (item_i.byte_value == efv_pkg::HeaderByte);
      bytes_seen_d   = efv_pkg::FirstByteSeen;
      length_phase_d = efv_pkg::PhaseAfterHeader;
      records_seen_d = '0;
    end else begin
      if (bytes_seen_q < efv_pkg::MinLength) begin
        bytes_seen_d = bytes_seen_q + efv_pkg::SeenW'(1);
      end
      length_phase_d = (length_phase_q >= efv_pkg::PhaseAfterHeader) ?
                       efv_pkg::PhaseRecordEnd : length_phase_q + efv_pkg::PhaseW'(1);
      if ((length_phase_d == efv_pkg::PhaseRecordEnd) &&
          (bytes_seen_d == efv_pkg::MinLength) &&
          (records_seen_q < RecW'(MAX_RECORDS))) begin
        records_seen_d = records_seen_q + RecW'(1);
      end
    end
    closes_frame    = (bytes_seen_d == efv_pkg::MinLength) &&
                      (length_phase_d == efv_pkg::PhaseRecordEnd) &&
                      previous_byte_q[efv_pkg::FlagBitIdx];
    running_sum_d   = (bytes_seen_d == efv_pkg::FirstByteSeen) ? '0 :
                      running_sum_q + item_i.byte_value;
    previous_byte_d = item_i.byte_value;
  end

  always_comb begin
    if (!header_good_d) begin
      result_o.verdict = efv_pkg::VERDICT_INVALID;
    end else if (closes_frame) begin
      result_o.verdict = (running_sum_q == item_i.byte_value) ?
                         efv_pkg::VERDICT_VALID : efv_pkg::VERDICT_INVALID;
    end else begin
      result_o.verdict = efv_pkg::VERDICT_INCOMPLETE;
    end
    records_ext           = {{efv_pkg::CountW{1'b0}}, records_seen_d};
    result_o.record_count = records_ext[efv_pkg::CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_good_q   <= 1'b0;
      bytes_seen_q    <= '0;
      length_phase_q  <= '0;
      previous_byte_q <= '0;
      running_sum_q   <= '0;
      records_seen_q  <= '0;
    end else if (advance_i) begin
      header_good_q   <= header_good_d;
      bytes_seen_q    <= bytes_seen_d;
      length_phase_q  <= length_phase_d;
      previous_byte_q <= previous_byte_d;
      running_sum_q   <= running_sum_d;
      records_seen_q  <= records_seen_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/efv_out_stage.sv
// Result register of the event frame validator: holds one verdict until taken.
// Depends on efv_pkg for the result type.
`default_nettype none

module efv_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  efv_pkg::result_t   result_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output efv_pkg::result_t   result_o
);

  logic             valid_q;
  logic             valid_d;
  efv_pkg::result_t result_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

FILE: hdl/event_frame_validator.sv
// Top level of the event frame validator: input register, frame check, result register.
// Depends on efv_pkg, efv_in_stage, efv_frame_check and efv_out_stage.
//
//   Channel  Direction  Content
//   s_axis   in         tdata: byte_value[7:0]; tuser: frame_start
//   m_axis   out        tdata: verdict[1:0], record_count[8:2], zero [15:9]
//
// One byte request is accepted per cycle while m_axis is not stalled; its verdict is
// offered on m_axis after it has passed the input register and then the result register.
// The rate is set by the combinational update of the sum, phase and counters.
// Reset clears the frame state, so the first byte after reset opens a frame.
// A stalled output holds its result and back-pressure reaches the input in the same cycle.
`default_nettype none

module event_frame_validator #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // byte_value
  input  wire logic        s_axis_tuser_i,   // frame_start
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [efv_pkg::OutTdataW-1:0] m_axis_tdata_o  // verdict, record_count, zero padding
);

  efv_pkg::item_t   in_item;
  efv_pkg::item_t   held_item;
  efv_pkg::result_t check_result;
  efv_pkg::result_t out_result;
  logic             held_valid;
  logic             out_ready;

  assign in_item.byte_value  = s_axis_tdata_i;
  assign in_item.frame_start = s_axis_tuser_i;

  efv_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .ready_i (out_ready),
    .item_o  (held_item)
  );

  efv_frame_check #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_frame_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (held_valid && out_ready),
    .item_i    (held_item),
    .result_o  (check_result)
  );

  efv_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (held_valid),
    .ready_o  (out_ready),
    .result_i (check_result),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_result)
  );

  assign m_axis_tdata_o = {7'b0, out_result.record_count, 2'(out_result.verdict)};

endmodule

`default_nettype wire
